// ===== rtl/core/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and codes for the circular FIFO queue: request op codes,
// result status codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_SHOW = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       push;       // write data_in at the tail
    logic       pop;        // advance the head
    logic       rd_head;    // read the entry at the head
    logic       rd_walk;    // read the entry at the walk pointer and advance it
    logic       walk_load;  // start a display walk behind the head
    logic       emit;       // present a result next cycle
    logic       echo;       // result word is data_in rather than zero
    logic [1:0] status;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_held;   // exactly one entry held
    logic walk_last;  // the walk pointer sits on the newest entry
  } dp_stat_t;

endpackage

// ===== rtl/core/cfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfq_ctrl
// Controller for the circular FIFO queue. Decodes each request and steps a
// display walk over the held entries, one entry per cycle.
// ----------------------------------------------------------------------------
module cfq_ctrl
  import cfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SHOW = 1'b1;

  logic state_r;
  logic state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          case (in_op)
            OP_ENQ: begin
              cmd.echo = 1'b1;
              if (stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.push   = 1'b1;
                cmd.status = ST_OK;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (stat.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.rd_head = 1'b1;
                cmd.pop     = (in_op == OP_DEQ);
                cmd.status  = ST_OK;
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.rd_head   = 1'b1;
                cmd.walk_load = 1'b1;
                cmd.status    = ST_OK;
                cmd.last      = stat.one_held;
                if (!stat.one_held) begin
                  state_nxt = S_SHOW;
                end
              end
            end
          endcase
        end
      end
      S_SHOW: begin
        busy        = 1'b1;
        cmd.emit    = 1'b1;
        cmd.rd_walk = 1'b1;
        cmd.status  = ST_OK;
        cmd.last    = stat.walk_last;
        if (stat.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cfq_datapath.sv =====
// ----------------------------------------------------------------------------
// cfq_datapath
// Datapath of the circular FIFO queue: entry memory, head/tail pointers,
// held count, display walk pointer and the registered result.
// ----------------------------------------------------------------------------
module cfq_datapath
  import cfq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic signed [31:0] data_in,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic signed [31:0] data_out,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_MAX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic signed [31:0] mem [DEPTH];

  logic [AW-1:0]      head_r;
  logic [AW-1:0]      tail_r;
  logic [AW-1:0]      pos_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      rem_r;
  logic signed [31:0] rd_data_r;
  logic signed [31:0] word_r;
  logic               sel_mem_r;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic               last_r;
  logic [AW-1:0]      rd_addr;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + AW'(1);
  endfunction

  assign rd_addr = cmd.rd_walk ? pos_r : head_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= data_in;
    end
    if (cmd.rd_head || cmd.rd_walk) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        tail_r  <= next_ptr(tail_r);
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        head_r  <= next_ptr(head_r);
        count_r <= count_r - CW'(1);
      end
    end
  end

  // The walk starts one entry behind the head, since the head itself is
  // read in the accepting cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rem_r <= '0;
    end else if (cmd.walk_load) begin
      pos_r <= next_ptr(head_r);
      rem_r <= count_r - CW'(1);
    end else if (cmd.rd_walk) begin
      pos_r <= next_ptr(pos_r);
      rem_r <= rem_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sel_mem_r <= cmd.rd_head || cmd.rd_walk;
      word_r    <= cmd.echo ? data_in : '0;
      status_r  <= cmd.status;
      last_r    <= cmd.last;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_FULL);
  assign stat.one_held  = (count_r == CNT_ONE);
  assign stat.walk_last = (rem_r == CNT_ONE);

  assign out_valid = out_valid_r;
  assign data_out  = sel_mem_r ? rd_data_r : word_r;
  assign status    = status_r;
  assign last      = last_r;

endmodule

// ===== rtl/core/circular_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of DEPTH signed 32-bit words with enqueue, dequeue, peek
// and display requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; in_op
//   selects enqueue, dequeue, peek or display, in_data_in is the word to
//   enqueue. Each result appears for one cycle with out_valid high, carrying
//   out_data_out, out_status (ok, full, empty) and out_last on the final
//   result of the request.
//   Enqueue, dequeue and peek give one result in the cycle after the request
//   and keep busy low, so a new request is taken every cycle.
//   Display of N held entries gives N results in consecutive cycles, one
//   memory read per entry, starting the cycle after the request; busy is
//   high for the walk after the first entry, so no new request is taken
//   until the walk ends. Display of an empty queue gives one result.
//   The receiver cannot stall: every result is taken in its cycle.
//   Reset empties the queue and clears the head and tail pointers; the
//   memory contents are left as they are and are never read unwritten.
// ----------------------------------------------------------------------------
module circular_fifo_queue
  import cfq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_data_in,
  output logic               out_valid,
  output logic signed [31:0] out_data_out,
  output logic [1:0]         out_status,
  output logic               out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_in   (in_data_in),
    .stat      (stat),
    .out_valid (out_valid),
    .data_out  (out_data_out),
    .status    (out_status),
    .last      (out_last)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_fifo_queue. A directed table covers
// empty and full queues, the data extremes, pointer wrap and display walks.
// A random phase follows that swings the queue between filling and draining.
// Each result is checked field by field against a mirror of the queue or a pinned row's result.
// ----------------------------------------------------------------------------
module tb
  import cfq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH         = 8;
  localparam int RANDOM_ITEMS   = 410;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } queue_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] data;
    logic        pinned;
    logic [31:0] pin_data;
    logic [1:0]  pin_status;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic signed [31:0] in_data_in;
  logic               out_valid;
  logic signed [31:0] out_data_out;
  logic [1:0]         out_status;
  logic               out_last;

  // A pinned row carries its own expected result alongside the request.
  logic               req_pinned;
  queue_result_t      req_pin;

  logic [31:0]   mirror_words [QDEPTH];
  int            mirror_head;
  int            mirror_tail;
  int            mirror_count;
  queue_result_t pending_results [$];
  int            accepted_count;
  int            mismatch_count;
  int            stall_cycles;

  stim_row_t directed_rows [23] = '{
    '{OP_PEEK, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{OP_DEQ,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{OP_SHOW, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{OP_ENQ,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
    '{OP_ENQ,  32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_ENQ,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{OP_ENQ,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PEEK, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
    '{OP_SHOW, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'h1234_5678, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, ST_FULL},
    '{OP_SHOW, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_DEQ,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
    '{OP_DEQ,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_ENQ,  32'h0F0F_0F0F, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'hF0F0_F0F0, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ENQ,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_FULL},
    '{OP_SHOW, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_PEEK, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_DEQ,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
  };

  circular_fifo_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  always #2 clk = ~clk;

  // Mirror of the queue: updates its state and queues the results a request
  // should produce, in order.
  task automatic predict_queue_op(input logic [1:0] op, input logic [31:0] data,
                                  input logic pinned, input queue_result_t pin);
    queue_result_t outcome [$];
    int pos;
    case (op)
      OP_ENQ: begin
        if (mirror_count == QDEPTH) begin
          outcome.push_back({data, ST_FULL, 1'b1});
        end else begin
          mirror_words[mirror_tail] = data;
          mirror_tail = (mirror_tail + 1) % QDEPTH;
          mirror_count++;
          outcome.push_back({data, ST_OK, 1'b1});
        end
      end
      OP_DEQ: begin
        if (mirror_count == 0) begin
          outcome.push_back({32'h0, ST_EMPTY, 1'b1});
        end else begin
          outcome.push_back({mirror_words[mirror_head], ST_OK, 1'b1});
          mirror_head = (mirror_head + 1) % QDEPTH;
          mirror_count--;
        end
      end
      OP_PEEK: begin
        if (mirror_count == 0) begin
          outcome.push_back({32'h0, ST_EMPTY, 1'b1});
        end else begin
          outcome.push_back({mirror_words[mirror_head], ST_OK, 1'b1});
        end
      end
      default: begin
        if (mirror_count == 0) begin
          outcome.push_back({32'h0, ST_EMPTY, 1'b1});
        end else begin
          pos = mirror_head;
          for (int i = 0; i < mirror_count; i++) begin
            outcome.push_back({mirror_words[pos], ST_OK, (i + 1 == mirror_count)});
            pos = (pos + 1) % QDEPTH;
          end
        end
      end
    endcase
    if (pinned) begin
      pending_results.push_back(pin);
    end else begin
      foreach (outcome[i]) pending_results.push_back(outcome[i]);
    end
  endtask

  task automatic note_mismatch(input string what, input queue_result_t want,
                               input queue_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected data=%h status=%0d last=%0b, got data=%h status=%0d last=%0b",
               $realtime, what, want.data, want.status, want.last,
               got.data, got.status, got.last);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    bit progress;
    if (!rst_n) begin
      stall_cycles = 0;
    end else begin
      progress = 1'b0;
      if (out_valid === 1'b1) begin
        progress = 1'b1;
        got = {out_data_out, out_status, out_last};
        if (pending_results.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.data !== want.data) note_mismatch("data_out", want, got);
          else if (got.status !== want.status) note_mismatch("status", want, got);
          else if (got.last !== want.last) note_mismatch("last", want, got);
        end
      end else if (out_valid !== 1'b0) begin
        note_mismatch("out_valid unknown", '0, '0);
      end
      if (start && busy === 1'b0) begin
        progress = 1'b1;
        accepted_count++;
        predict_queue_op(in_op, in_data_in, req_pinned, req_pin);
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request
  // is taken, so the next request can follow without a gap.
  task automatic send_request(input logic [1:0] op, input logic [31:0] data,
                              input logic pinned, input queue_result_t pin);
    int target;
    target = accepted_count + 1;
    start      <= 1'b1;
    in_op      <= op;
    in_data_in <= data;
    req_pinned <= pinned;
    req_pin    <= pin;
    do @(negedge clk); while (accepted_count < target);
  endtask

  task automatic sender_gap(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 3) begin
      start      <= 1'b0;
      in_op      <= 2'($urandom_range(0, 3));
      in_data_in <= $urandom;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bit          filling;
    int          phase_left;
    int          pick;
    logic [1:0]  op;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_ENQ;
    in_data_in     = '0;
    req_pinned     = 1'b0;
    req_pin        = '0;
    mirror_head    = 0;
    mirror_tail    = 0;
    mirror_count   = 0;
    accepted_count = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    foreach (mirror_words[i]) mirror_words[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pinned,
                   {directed_rows[i].pin_data, directed_rows[i].pin_status, 1'b1});
      sender_gap(1'b1);
    end

    // The random part alternates between a fill bias and a drain bias so the
    // queue keeps hitting full, empty and every pointer wrap.
    filling    = 1'b1;
    phase_left = $urandom_range(10, 40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 60) op = filling ? OP_ENQ : OP_DEQ;
      else if (pick < 75) op = filling ? OP_DEQ : OP_ENQ;
      else if (pick < 87) op = OP_PEEK;
      else op = OP_SHOW;
      send_request(op, random_word(), 1'b0, '0);
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end else begin
        sender_gap(n < 260 || n > 360);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QDEPTH + 4) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
